@@ rtl/core/sawa_pkg.sv @@
// ----------------------------------------------------------------------------
// sawa_pkg
// Shared codes, defaults and controller/datapath interface types for the
// stop-and-wait arq endpoint.
// ----------------------------------------------------------------------------
package sawa_pkg;

   // default sizes
   localparam int PAYLOAD_BYTES_DEF = 20;
   localparam int SEQ_WIDTH_DEF     = 20;

   // timer load after reset
   localparam logic [15:0] TIMEOUT_RESET = 16'd200;

   // input item kinds
   localparam logic [1:0] KIND_NET = 2'd0;
   localparam logic [1:0] KIND_MSG = 2'd1;
   localparam logic [1:0] KIND_EXP = 2'd2;

   // result destinations
   localparam logic [1:0] DEST_NET = 2'd0;
   localparam logic [1:0] DEST_UP  = 2'd1;
   localparam logic [1:0] DEST_TMR = 2'd2;

   // timer commands
   localparam logic [1:0] TMR_NONE    = 2'd0;
   localparam logic [1:0] TMR_START   = 2'd1;
   localparam logic [1:0] TMR_STOP    = 2'd2;
   localparam logic [1:0] TMR_RESTART = 2'd3;

   // what a finished item emits
   typedef enum logic [1:0] {
      PLAN_NONE,
      PLAN_TIMER,
      PLAN_SEND,
      PLAN_SEND2
   } plan_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic decide;
      logic load;
      logic first;
      logic last;
      logic deliver;
      logic tmr_word;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic     completes;
      plan_type plan;
   } dp_status_type;

endpackage

@@ rtl/core/sawa_dp.sv @@
// ----------------------------------------------------------------------------
// sawa_dp
// Datapath: byte assembly, checksum, protocol state, payload buffers,
// run descriptor and the result word register.
// ----------------------------------------------------------------------------
module sawa_dp #(
   parameter int PAYLOAD_BYTES = sawa_pkg::PAYLOAD_BYTES_DEF,
   parameter int SEQ_WIDTH     = sawa_pkg::SEQ_WIDTH_DEF,
   parameter int IW            = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sawa_pkg::ctl_cmd_type  cmd,
   input  logic [IW-1:0]          idx,
   output sawa_pkg::dp_status_type status,
   // input word
   input  logic [1:0]             kind,
   input  logic [19:0]            seq_in,
   input  logic signed [20:0]     ack_in,
   input  logic signed [31:0]     check_in,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   // configuration
   input  logic                   csr_write,
   input  logic [15:0]            csr_value,
   // result word
   output logic [1:0]             dest,
   output logic [19:0]            seq_out,
   output logic signed [20:0]     ack_out,
   output logic signed [31:0]     check_out,
   output logic [7:0]             byte_out,
   output logic                   last_out,
   output logic [1:0]             timer_cmd,
   output logic [15:0]            timer_load
);
   import sawa_pkg::*;

   localparam logic [IW-1:0] LAST_IDX = IW'(PAYLOAD_BYTES - 1);

   // protocol state
   logic [15:0]          timeout_ff;
   logic [SEQ_WIDTH-1:0] next_seq_ff, next_seq_in;
   logic [19:0]          last_del_ff;
   logic                 busy_ff, await_ff;
   logic [SEQ_WIDTH-1:0] held_seq_ff;
   logic [31:0]          held_check_ff, held_check_in;

   // assembly state
   logic [19:0]   rx_seq_ff;
   logic [20:0]   rx_ack_ff;
   logic [31:0]   rx_check_ff;
   logic [1:0]    rx_kind_ff;
   logic          pend_timer_ff;
   logic [IW-1:0] count_ff;
   logic [31:0]   sum_ff;

   // payload buffers
   logic [7:0] rx_buf_ff   [PAYLOAD_BYTES];
   logic [7:0] held_buf_ff [PAYLOAD_BYTES];

   // run descriptor
   logic        run_held_ff, run_held_in;
   logic [19:0] run_seq_ff, run_seq_in;
   logic [20:0] run_ack_ff, run_ack_in;
   logic [31:0] run_check_ff, run_check_in;
   logic [1:0]  run_cmd_ff, run_cmd_in;

   // result word register
   logic [1:0]  dest_ff;
   logic [19:0] seq_out_ff;
   logic [20:0] ack_out_ff;
   logic [31:0] check_out_ff;
   logic [7:0]  byte_out_ff;
   logic        last_out_ff;
   logic [1:0]  tcmd_ff;
   logic [15:0] tload_ff;

   logic        is_byte;
   logic [31:0] byte_sext;
   logic [31:0] ack_sext;
   logic [31:0] calc;
   logic        sum_good;
   logic [31:0] held_seq32, next_seq32;
   logic        take_msg, clr_busy, clr_await, set_del;
   plan_type    plan;

   // item assembly status
   assign is_byte   = (kind == KIND_NET) || (kind == KIND_MSG);
   assign byte_sext = {{24{data_byte[7]}}, data_byte};
   assign status.completes = (kind == KIND_EXP) ||
                             (is_byte && (last_byte || count_ff == LAST_IDX));
   assign status.plan = plan;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sum_ff        <= '0;
         rx_seq_ff     <= '0;
         rx_ack_ff     <= '0;
         rx_check_ff   <= '0;
         rx_kind_ff    <= KIND_NET;
         pend_timer_ff <= 1'b0;
      end else if (cmd.accept) begin
         if (status.completes) begin
            pend_timer_ff <= (kind == KIND_EXP);
         end
         if (is_byte) begin
            if (count_ff == '0) begin
               rx_seq_ff   <= seq_in;
               rx_ack_ff   <= ack_in;
               rx_check_ff <= check_in;
               rx_kind_ff  <= kind;
               sum_ff      <= byte_sext;
            end else begin
               sum_ff <= sum_ff + byte_sext;
            end
            count_ff <= status.completes ? '0 : count_ff + 1'b1;
         end
      end
   end

   // receive buffer, cleared on the first byte of an item
   always_ff @(posedge clock) begin
      if (cmd.accept && is_byte) begin
         for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            if (count_ff == '0) begin
               rx_buf_ff[i] <= (i == 0) ? data_byte : 8'h00;
            end else if (IW'(i) == count_ff) begin
               rx_buf_ff[i] <= data_byte;
            end
         end
      end
   end

   // finish decision
   assign ack_sext   = {{11{rx_ack_ff[20]}}, rx_ack_ff};
   assign calc       = {12'h000, rx_seq_ff} + ack_sext + sum_ff;
   assign sum_good   = (calc == rx_check_ff);
   assign held_seq32 = 32'(held_seq_ff);
   assign next_seq_in = next_seq_ff + 1'b1;
   assign next_seq32 = 32'(next_seq_in);
   assign held_check_in = next_seq32 + sum_ff;

   always_comb begin
      plan         = PLAN_NONE;
      take_msg     = 1'b0;
      clr_busy     = 1'b0;
      clr_await    = 1'b0;
      set_del      = 1'b0;
      run_held_in  = 1'b1;
      run_seq_in   = held_seq32[19:0];
      run_ack_in   = '0;
      run_check_in = held_check_ff;
      run_cmd_in   = TMR_NONE;
      if (pend_timer_ff) begin
         plan       = PLAN_SEND;
         run_cmd_in = TMR_START;
      end else if (rx_kind_ff == KIND_MSG) begin
         if (!busy_ff) begin
            plan         = PLAN_SEND;
            take_msg     = 1'b1;
            run_seq_in   = next_seq32[19:0];
            run_check_in = held_check_in;
            run_cmd_in   = TMR_START;
         end
      end else if (sum_good) begin
         if (rx_ack_ff == '0) begin
            // data packet: ack echo, then upward delivery if new
            clr_await    = 1'b1;
            run_held_in  = 1'b0;
            run_seq_in   = rx_seq_ff;
            run_ack_in   = {1'b0, rx_seq_ff};
            run_check_in = {12'h000, rx_seq_ff} + {12'h000, rx_seq_ff} + sum_ff;
            set_del      = (last_del_ff != rx_seq_ff);
            plan         = set_del ? PLAN_SEND2 : PLAN_SEND;
         end else if (!rx_ack_ff[20]) begin
            clr_await = 1'b1;
            clr_busy  = 1'b1;
            plan      = PLAN_TIMER;
         end else begin
            plan       = PLAN_SEND;
            run_cmd_in = TMR_RESTART;
         end
      end else if (!await_ff) begin
         // corrupt packet answered with a nack
         plan         = PLAN_SEND;
         run_held_in  = 1'b0;
         run_seq_in   = rx_seq_ff;
         run_ack_in   = 21'd0 - {1'b0, rx_seq_ff};
         run_check_in = sum_ff;
      end
   end

   // protocol state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         next_seq_ff   <= '0;
         last_del_ff   <= '0;
         busy_ff       <= 1'b0;
         await_ff      <= 1'b0;
         held_seq_ff   <= '0;
         held_check_ff <= '0;
      end else begin
         if (csr_write) begin
            timeout_ff <= csr_value;
         end
         if (cmd.decide) begin
            if (take_msg) begin
               busy_ff       <= 1'b1;
               await_ff      <= 1'b1;
               next_seq_ff   <= next_seq_in;
               held_seq_ff   <= next_seq_in;
               held_check_ff <= held_check_in;
            end
            if (clr_busy) begin
               busy_ff <= 1'b0;
            end
            if (clr_await) begin
               await_ff <= 1'b0;
            end
            if (set_del) begin
               last_del_ff <= rx_seq_ff;
            end
         end
      end
   end

   // held copy and run descriptor
   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         run_held_ff  <= run_held_in;
         run_seq_ff   <= run_seq_in;
         run_ack_ff   <= run_ack_in;
         run_check_ff <= run_check_in;
         run_cmd_ff   <= run_cmd_in;
         if (take_msg) begin
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
               held_buf_ff[i] <= rx_buf_ff[i];
            end
         end
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         last_out_ff <= cmd.last;
         if (cmd.tmr_word) begin
            dest_ff      <= DEST_TMR;
            seq_out_ff   <= '0;
            ack_out_ff   <= '0;
            check_out_ff <= '0;
            byte_out_ff  <= '0;
            tcmd_ff      <= TMR_STOP;
            tload_ff     <= timeout_ff;
         end else if (cmd.deliver) begin
            dest_ff      <= DEST_UP;
            seq_out_ff   <= run_seq_ff;
            ack_out_ff   <= '0;
            check_out_ff <= '0;
            byte_out_ff  <= rx_buf_ff[idx];
            tcmd_ff      <= TMR_NONE;
            tload_ff     <= '0;
         end else begin
            dest_ff      <= DEST_NET;
            seq_out_ff   <= run_seq_ff;
            ack_out_ff   <= run_ack_ff;
            check_out_ff <= run_check_ff;
            byte_out_ff  <= run_held_ff ? held_buf_ff[idx] : rx_buf_ff[idx];
            tcmd_ff      <= cmd.first ? run_cmd_ff : TMR_NONE;
            tload_ff     <= (cmd.first && run_cmd_ff != TMR_NONE) ? timeout_ff : 16'h0000;
         end
      end
   end

   assign dest       = dest_ff;
   assign seq_out    = seq_out_ff;
   assign ack_out    = ack_out_ff;
   assign check_out  = check_out_ff;
   assign byte_out   = byte_out_ff;
   assign last_out   = last_out_ff;
   assign timer_cmd  = tcmd_ff;
   assign timer_load = tload_ff;

endmodule

@@ rtl/core/sawa_ctrl.sv @@
// ----------------------------------------------------------------------------
// sawa_ctrl
// Controller: input acceptance, finish decision step and result replay
// sequencing into the result word register.
// ----------------------------------------------------------------------------
module sawa_ctrl #(
   parameter int PAYLOAD_BYTES = sawa_pkg::PAYLOAD_BYTES_DEF,
   parameter int IW            = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  sawa_pkg::dp_status_type status,
   output sawa_pkg::ctl_cmd_type   cmd,
   output logic [IW-1:0]           idx
);
   import sawa_pkg::*;

   localparam logic [IW-1:0] LAST_IDX = IW'(PAYLOAD_BYTES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_RUN
   } state_type;

   state_type     state_ff;
   logic [IW-1:0] idx_ff;
   logic          valid_ff;
   logic          single_ff;
   logic          pend2_ff;
   logic          deliver_ff;

   // commands to the datapath
   always_comb begin
      cmd.accept   = req_tvalid && (state_ff == ST_IDLE);
      cmd.decide   = (state_ff == ST_DECIDE);
      cmd.load     = (state_ff == ST_RUN) && (!valid_ff || rsp_tready);
      cmd.first    = (idx_ff == '0) && !deliver_ff;
      cmd.last     = single_ff || (idx_ff == LAST_IDX && !pend2_ff);
      cmd.deliver  = deliver_ff;
      cmd.tmr_word = single_ff;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign idx        = idx_ff;

   // state and sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         idx_ff     <= '0;
         valid_ff   <= 1'b0;
         single_ff  <= 1'b0;
         pend2_ff   <= 1'b0;
         deliver_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.accept && status.completes) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               idx_ff     <= '0;
               deliver_ff <= 1'b0;
               single_ff  <= (status.plan == PLAN_TIMER);
               pend2_ff   <= (status.plan == PLAN_SEND2);
               state_ff   <= (status.plan == PLAN_NONE) ? ST_IDLE : ST_RUN;
            end
            ST_RUN: begin
               if (cmd.load) begin
                  if (cmd.last) begin
                     state_ff <= ST_IDLE;
                  end else if (idx_ff == LAST_IDX) begin
                     idx_ff     <= '0;
                     pend2_ff   <= 1'b0;
                     deliver_ff <= 1'b1;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // a loaded word is shown next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> valid_ff)
      else $error("loaded word not presented");

   // the decision step lasts a single cycle
   a_decide_once: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> !cmd.decide)
      else $error("decision step repeated");

   // the final word of a run returns the controller to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && cmd.last) |=> (state_ff == ST_IDLE))
      else $error("run did not end after last word");

   // no input is taken while a run is in progress
   a_no_accept_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !req_tready)
      else $error("input accepted during replay");

endmodule

@@ rtl/core/stop_and_wait_arq_entity_core.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_arq_entity_core
// Stop-and-wait arq endpoint with nack: assembles byte-serial packets and
// messages, checks sums, and replays packets toward network and upper layer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | content
//  req     | in        | req_tvalid/tready  | tdata header+byte, tuser kind, tlast
//  rsp     | out       | rsp_tvalid/tready  | tdata header+byte+timer, tuser dest
//  csr     | in        | csr_valid/ready    | csr_data timeout value
//
//  a byte that does not finish an item leaves the controller idle
//  a finishing word adds a decision step, then, without rsp stalls, 0, 1,
//  PAYLOAD_BYTES or 2*PAYLOAD_BYTES result words leave the output register
//  one per cycle; reset is synchronous and active high; no clearing pass
//  is needed; rsp stalls hold the output register; req_tready is low during replay
// ----------------------------------------------------------------------------
module stop_and_wait_arq_entity_core #(
   parameter int PAYLOAD_BYTES = sawa_pkg::PAYLOAD_BYTES_DEF,
   parameter int SEQ_WIDTH     = sawa_pkg::SEQ_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // seq_in[19:0], ack_in[40:20], check_in[72:41], data_byte[80:73]
   input  logic [87:0]  req_tdata,
   // kind[1:0]
   input  logic [1:0]   req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // seq_out[19:0], ack_out[40:20], check_out[72:41], byte_out[80:73],
   // timer_cmd[82:81], timer_load[98:83]
   output logic [103:0] rsp_tdata,
   // dest[1:0]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);
   import sawa_pkg::*;

   localparam int IW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic [IW-1:0] idx;

   logic [19:0]        seq_out;
   logic signed [20:0] ack_out;
   logic signed [31:0] check_out;
   logic [7:0]         byte_out;
   logic [1:0]         timer_cmd;
   logic [15:0]        timer_load;

   assign csr_ready = 1'b1;

   // controller
   sawa_ctrl #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .IW            (IW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .idx        (idx)
   );

   // datapath
   sawa_dp #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .SEQ_WIDTH     (SEQ_WIDTH),
      .IW            (IW)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .idx        (idx),
      .status     (status),
      .kind       (req_tuser),
      .seq_in     (req_tdata[19:0]),
      .ack_in     (req_tdata[40:20]),
      .check_in   (req_tdata[72:41]),
      .data_byte  (req_tdata[80:73]),
      .last_byte  (req_tlast),
      .csr_write  (csr_valid && csr_ready),
      .csr_value  (csr_data),
      .dest       (rsp_tuser),
      .seq_out    (seq_out),
      .ack_out    (ack_out),
      .check_out  (check_out),
      .byte_out   (byte_out),
      .last_out   (rsp_tlast),
      .timer_cmd  (timer_cmd),
      .timer_load (timer_load)
   );

   // result word packing
   assign rsp_tdata = {5'b00000, timer_load, timer_cmd, byte_out, check_out, ack_out, seq_out};

endmodule

@@ verif/sawa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawa_checker
// Watches the req, rsp and csr channels of the arq endpoint, predicts the
// result words of every accepted request word and compares them in order.
// ----------------------------------------------------------------------------
module sawa_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [87:0]  req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [15:0]  csr_data,
   output int           errors,
   output int           pending
);
   import sawa_pkg::*;

   localparam int NB = PAYLOAD_BYTES_DEF;

   typedef struct {
      logic [1:0]  dest;
      logic [19:0] seq;
      logic [20:0] ack;
      logic [31:0] chk;
      logic [7:0]  b;
      logic        last;
      logic [1:0]  cmd;
      logic [15:0] load;
   } rsp_word_type;

   rsp_word_type expected_words[$];

   // endpoint state copy
   logic [15:0] timeout_q;
   logic [19:0] next_seq_q, last_del_q, held_seq_q, rx_seq_q;
   logic        busy_q, awaiting_q;
   logic [31:0] held_chk_q, rx_ack_q, rx_chk_q, sum_q;
   logic [1:0]  rx_kind_q;
   logic [7:0]  held_pl[NB];
   logic [7:0]  rx_pl[NB];
   int          fill_q;

   assign pending = expected_words.size();

   function automatic logic [31:0] sx8(logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

   task automatic report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   task automatic put_word(logic [1:0] dest, logic [31:0] seq, logic [31:0] ack,
                           logic [31:0] chk, logic [7:0] b, logic [1:0] cmd);
      rsp_word_type w;
      w.dest = dest;
      w.seq  = seq[19:0];
      w.ack  = ack[20:0];
      w.chk  = chk;
      w.b    = b;
      w.last = 1'b0;
      w.cmd  = cmd;
      w.load = (cmd != TMR_NONE) ? timeout_q : 16'd0;
      expected_words.push_back(w);
   endtask

   task automatic put_packet(logic [1:0] dest, logic [31:0] seq, logic [31:0] ack,
                             logic [31:0] chk, input logic [7:0] p[NB],
                             logic [1:0] cmd);
      for (int i = 0; i < NB; i++) begin
         put_word(dest, seq, ack, chk, p[i], (i == 0) ? cmd : TMR_NONE);
      end
   endtask

   // end of a network packet: check sum, then ack / deliver / stop / resend / nack
   task automatic close_packet();
      logic [31:0] calc;
      calc = {12'd0, rx_seq_q} + rx_ack_q + sum_q;
      if (calc == rx_chk_q) begin
         if (rx_ack_q == 0) begin
            awaiting_q = 1'b0;
            put_packet(DEST_NET, rx_seq_q, rx_seq_q,
                       {12'd0, rx_seq_q} + {12'd0, rx_seq_q} + sum_q, rx_pl, TMR_NONE);
            if (last_del_q != rx_seq_q) begin
               last_del_q = rx_seq_q;
               put_packet(DEST_UP, rx_seq_q, 0, 0, rx_pl, TMR_NONE);
            end
         end else if (!rx_ack_q[31]) begin
            awaiting_q = 1'b0;
            busy_q     = 1'b0;
            put_word(DEST_TMR, 0, 0, 0, 0, TMR_STOP);
         end else begin
            put_packet(DEST_NET, held_seq_q, 0, held_chk_q, held_pl, TMR_RESTART);
         end
      end else if (!awaiting_q) begin
         put_packet(DEST_NET, rx_seq_q, 32'd0 - {12'd0, rx_seq_q}, sum_q, rx_pl,
                    TMR_NONE);
      end
   endtask

   // end of an upper-layer message: dropped while busy
   task automatic close_message();
      if (busy_q) return;
      busy_q     = 1'b1;
      awaiting_q = 1'b1;
      next_seq_q = next_seq_q + 1'b1;
      held_seq_q = next_seq_q;
      held_chk_q = {12'd0, held_seq_q} + sum_q;
      held_pl    = rx_pl;
      put_packet(DEST_NET, held_seq_q, 0, held_chk_q, held_pl, TMR_START);
   endtask

   task automatic predict_word(logic [1:0] kind, logic [87:0] d, logic last);
      int n0;
      n0 = expected_words.size();
      if (kind == KIND_EXP) begin
         put_packet(DEST_NET, held_seq_q, 0, held_chk_q, held_pl, TMR_START);
      end else if (kind == KIND_NET || kind == KIND_MSG) begin
         if (fill_q == 0) begin
            rx_kind_q = kind;
            rx_seq_q  = d[19:0];
            rx_ack_q  = {{11{d[40]}}, d[40:20]};
            rx_chk_q  = d[72:41];
            sum_q     = 0;
            foreach (rx_pl[i]) rx_pl[i] = 8'd0;
         end
         rx_pl[fill_q] = d[80:73];
         sum_q = sum_q + sx8(d[80:73]);
         fill_q++;
         if (last || fill_q >= NB) begin
            fill_q = 0;
            if (rx_kind_q == KIND_MSG) close_message();
            else close_packet();
         end
      end
      if (expected_words.size() > n0) expected_words[expected_words.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      rsp_word_type w;
      if (reset) begin
         expected_words.delete();
         timeout_q  <= TIMEOUT_RESET;
         next_seq_q = 0; last_del_q = 0; held_seq_q = 0; rx_seq_q = 0;
         busy_q = 0; awaiting_q = 0; held_chk_q = 0; rx_ack_q = 0;
         rx_chk_q = 0; sum_q = 0; rx_kind_q = KIND_NET; fill_q = 0;
         foreach (held_pl[i]) held_pl[i] = 8'd0;
         foreach (rx_pl[i]) rx_pl[i] = 8'd0;
      end else begin
         // compare one result word
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report("result word with nothing expected");
            end else begin
               w = expected_words.pop_front();
               if (rsp_tuser !== w.dest)
                  report($sformatf("dest %0d exp %0d", rsp_tuser, w.dest));
               if (rsp_tdata[19:0] !== w.seq)
                  report($sformatf("seq %0h exp %0h", rsp_tdata[19:0], w.seq));
               if (rsp_tdata[40:20] !== w.ack)
                  report($sformatf("ack %0h exp %0h", rsp_tdata[40:20], w.ack));
               if (rsp_tdata[72:41] !== w.chk)
                  report($sformatf("check %0h exp %0h", rsp_tdata[72:41], w.chk));
               if (rsp_tdata[80:73] !== w.b)
                  report($sformatf("byte %0h exp %0h", rsp_tdata[80:73], w.b));
               if (rsp_tlast !== w.last)
                  report($sformatf("last %0b exp %0b", rsp_tlast, w.last));
               if (rsp_tdata[82:81] !== w.cmd)
                  report($sformatf("timer cmd %0d exp %0d", rsp_tdata[82:81], w.cmd));
               if (rsp_tdata[98:83] !== w.load)
                  report($sformatf("timer load %0d exp %0d", rsp_tdata[98:83], w.load));
            end
         end
         // predict from one request word
         if (req_tvalid && req_tready) predict_word(req_tuser, req_tdata, req_tlast);
         if (csr_valid && csr_ready) timeout_q <= csr_data;
      end
   end

endmodule

@@ verif/tb_stop_and_wait_arq_entity_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stop_and_wait_arq_entity_core
// Drives messages, data / ack / nack packets, corrupt packets and timer
// expiries into the arq endpoint with random idling on both sides, a long
// receiver hold-off and several timeout settings; the checker predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module tb_stop_and_wait_arq_entity_core;
   import sawa_pkg::*;

   localparam int NB        = PAYLOAD_BYTES_DEF;
   localparam int NUM_WORDS = 400;
   localparam int LIMIT     = 1500000;

   // kind code that the endpoint ignores
   localparam logic [1:0] KIND_UNDEF = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [87:0]  req_tdata = '0;
   logic [1:0]   req_tuser = KIND_NET;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_data = '0;

   int errors;
   int pending;
   int cycle_count = 0;
   int words_sent  = 0;
   bit quiet       = 0;
   bit hold_req    = 0;
   bit hold_done   = 0;
   bit have_msg    = 0;

   stop_and_wait_arq_entity_core i_dut (.*);

   sawa_checker i_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: random ready bursts, one long hold-off on request
   initial begin
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_req = 0;
         end else if (quiet || $urandom_range(0, 1)) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
      end
   end

   function automatic logic [31:0] sx8(logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

   function automatic logic [20:0] rand_ack();
      logic [20:0] a;
      do a = $urandom; while (a == 21'h100000);
      return a;
   endfunction

   // offer one request word and wait for it to be taken
   task automatic put_req(logic [1:0] kind, logic [19:0] seq, logic [20:0] ack,
                          logic [31:0] chk, logic [7:0] b, logic last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, b, chk, ack, seq};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (kind != KIND_UNDEF) words_sent++;
   endtask

   task automatic send_msg(int len, bit no_last);
      for (int i = 0; i < len; i++) begin
         put_req(KIND_MSG, $urandom, rand_ack(), $urandom, $urandom,
                 (i == len - 1) && !no_last);
      end
      have_msg = 1;
   endtask

   // packet with header on the first word; later words carry junk headers
   task automatic send_pkt(logic [19:0] seq, logic [20:0] ack, bit bad, int len);
      logic [7:0]  pl[NB];
      logic [31:0] chk;
      logic [1:0]  k;
      chk = {12'd0, seq} + {{11{ack[20]}}, ack};
      for (int i = 0; i < len; i++) begin
         pl[i] = $urandom;
         chk   = chk + sx8(pl[i]);
      end
      if (bad) chk = chk ^ ($urandom | 32'd1);
      for (int i = 0; i < len; i++) begin
         if (i == 0) begin
            put_req(KIND_NET, seq, ack, chk, pl[i], len == 1);
         end else begin
            if ($urandom_range(0, 15) == 0)
               put_req(KIND_UNDEF, $urandom, 0, $urandom, $urandom, 1);
            if (have_msg && $urandom_range(0, 30) == 0)
               put_req(KIND_EXP, $urandom, 0, $urandom, $urandom, $urandom);
            k = $urandom_range(0, 1) ? KIND_NET : KIND_MSG;
            put_req(k, $urandom, rand_ack(), $urandom, pl[i], i == len - 1);
         end
      end
   endtask

   // timeout write, only with the endpoint drained
   task automatic csr_write(logic [15:0] v);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (60) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int r;
      int next_cfg;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_msg(NB, 1);                           // full message, no last flag
      put_req(KIND_EXP, 0, 0, 0, 0, 0);         // expiry resends
      send_pkt(0, 21'h100001, 0, 3);             // good nack, negative of the most positive ack
      send_pkt(5, 0, 1, 2);                      // corrupt while awaiting first reply
      send_pkt(20'hFFFFF, 0, 0, 1);              // good data, delivered
      send_pkt(20'hFFFFF, 0, 0, 1);              // duplicate, ack only
      send_pkt(20'h00001, 0, 1, NB);             // corrupt, answered with nack
      send_pkt(0, 21'h0FFFFF, 0, 1);             // good ack, most positive
      put_req(KIND_UNDEF, 20'hFFFFF, 21'h1FFFFF, 32'hFFFFFFFF, 8'hFF, 1);
      send_pkt(3, 21'd1, 0, 1);                  // ack while idle
      csr_write(16'd1);
      send_msg(1, 0);
      send_msg(2, 0);                            // dropped while busy
      send_pkt(0, 0, 0, NB);
      csr_write(16'hFFFF);
      put_req(KIND_EXP, 0, 0, 0, 8'h80, 1);
      send_pkt(7, 21'd7, 0, 4);

      // random part
      next_cfg = words_sent + 100;
      while (words_sent < NUM_WORDS) begin
         if (words_sent > NUM_WORDS - 50) quiet = 1;
         if (!hold_done && words_sent > 150) begin
            hold_done = 1;
            hold_req  = 1;
         end
         if (words_sent > next_cfg && !quiet) begin
            csr_write($urandom_range(1, 65535));
            next_cfg = words_sent + 100;
         end
         r = $urandom_range(0, 9);
         if (r <= 3) begin
            send_msg($urandom_range(1, NB), $urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
               0: send_pkt($urandom, $urandom_range(1, 1048575), 0, $urandom_range(1, NB));
               1: send_pkt($urandom, -$urandom_range(1, 1048575), 0, $urandom_range(1, 4));
               2: send_pkt($urandom, rand_ack(), 1, $urandom_range(1, NB));
               default: put_req(KIND_EXP, $urandom, rand_ack(), $urandom, $urandom, $urandom);
            endcase
         end else if (r <= 5) begin
            send_pkt($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom, 0, 0,
                     $urandom_range(1, NB));
         end else if (r == 6) begin
            send_pkt($urandom, rand_ack(), 1, $urandom_range(1, NB));
         end else if (r == 7) begin
            put_req(KIND_EXP, $urandom, rand_ack(), $urandom, $urandom, $urandom);
         end else if (r == 8) begin
            put_req(KIND_UNDEF, $urandom, rand_ack(), $urandom, $urandom, $urandom);
         end else begin
            put_req($urandom_range(0, 1) ? KIND_NET : KIND_MSG, $urandom, rand_ack(),
                    $urandom, $urandom, $urandom);
         end
      end
      req_tvalid <= 1'b0;

      // drain and verdict
      do @(posedge clock); while (pending != 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
